// File: rtl/stdec_pkg.sv
`default_nettype none

package stdec_pkg;

   // Frame geometry: nine scratchpad bytes, byte 0 first.
   localparam int FRAME_BYTES = 9;
   localparam int IDX_W       = $clog2(FRAME_BYTES);
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(FRAME_BYTES - 1);

   // Scratchpad positions that are kept for decoding.
   localparam logic [IDX_W-1:0] POS_TEMP_LOW     = IDX_W'(0);
   localparam logic [IDX_W-1:0] POS_TEMP_HIGH    = IDX_W'(1);
   localparam logic [IDX_W-1:0] POS_CONFIG       = IDX_W'(4);
   localparam logic [IDX_W-1:0] POS_COUNT_REMAIN = IDX_W'(6);
   localparam logic [IDX_W-1:0] POS_COUNT_PER_DEG = IDX_W'(7);

   localparam logic [7:0] FAMILY_OLD = 8'h10;
   localparam logic [7:0] CPD_FULL   = 8'h10;
   localparam logic [7:0] CRC_POLY   = 8'h8C;

   // Resolution field of the configuration byte.
   localparam logic [7:0] RES_BITS = 8'h60;
   localparam logic [7:0] RES_9    = 8'h00;
   localparam logic [7:0] RES_10   = 8'h20;
   localparam logic [7:0] RES_11   = 8'h40;

   localparam logic signed [15:0] SENT_ABSENT = -16'sd27315;
   localparam logic signed [15:0] SENT_CRC    = -16'sd27314;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_CRC    = 2'd1,
      STATUS_ABSENT = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] temp_low;
      logic [7:0] temp_high;
      logic [7:0] config_byte;
      logic [7:0] count_remain;
      logic [7:0] count_per_degree;
   } scratch_type;

   typedef struct packed {
      logic last;
      logic crc_ok;
   } frame_flags_type;

   // Dallas CRC-8, reflected form, one byte.
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic [7:0] d;
      logic       mix;
      c = crc;
      d = b;
      for (int i = 0; i < 8; i++) begin
         mix = c[0] ^ d[0];
         c   = c >> 1;
         if (mix) begin
            c = c ^ CRC_POLY;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/temp_scratchpad_decoder_unit.sv
// Scratchpad decoder for a 1-Wire temperature sensor.
// Input channel req_*: one item per scratchpad byte, nine items make a frame,
// byte 0 first. Each item also carries the sensor family code (sampled on the
// ninth byte) and an absent flag in req_tuser.
// Result channel rsp_*: one item per completed frame, giving the temperature
// in hundredths of a degree and a status code (0 valid, 1 CRC error with
// -27314, 2 no sensor with -27315). An item flagged absent yields a result of
// its own at once and leaves the frame state untouched.
// The ninth byte (or the absent item) is loaded into the input register when
// it is accepted and from there into the result register, which drives
// rsp_tvalid. Throughput is one item per cycle while no result waits on a
// stalled receiver, set by the combinational CRC-8 byte update in the frame stage.
// Reset clears the byte position and the running CRC, and empties both
// registers. When the receiver stalls, the result register holds its item and
// the input register still takes bytes that produce no result; a second
// result then waits in the input register and req_tready falls.
`default_nettype none

module temp_scratchpad_decoder_unit
   import stdec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] family_code
   input  wire logic        req_tuser,   // [0] sensor_absent
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] temp_centi
   output logic [1:0]       rsp_tuser    // [1:0] status
);

   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_data_ff;
   logic [7:0]        s1_family_ff;
   logic              s1_absent_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [15:0]       rsp_temp_ff, rsp_temp_in;
   status_type        rsp_status_ff, rsp_status_in;

   frame_flags_type   flags;
   scratch_type       scratch;
   logic signed [15:0] decoded;

   logic s1_emit;
   logic out_free;
   logic s1_go;
   logic req_fire;

   assign s1_emit  = s1_absent_ff | flags.last;
   assign out_free = !rsp_valid_ff | rsp_tready;
   assign s1_go    = s1_valid_ff & (!s1_emit | out_free);
   assign req_tready = !s1_valid_ff | s1_go;
   assign req_fire = req_tvalid & req_tready;

   stdec_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (s1_go & !s1_absent_ff),
      .data_byte (s1_data_ff),
      .flags     (flags),
      .scratch   (scratch)
   );

   stdec_scale u_scale (
      .scratch     (scratch),
      .family_code (s1_family_ff),
      .temp_centi  (decoded)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_status_in = rsp_status_ff;
      if (s1_go && s1_emit) begin
         rsp_valid_in = 1'b1;
         if (s1_absent_ff) begin
            rsp_temp_in   = SENT_ABSENT;
            rsp_status_in = STATUS_ABSENT;
         end else if (flags.crc_ok) begin
            rsp_temp_in   = decoded;
            rsp_status_in = STATUS_OK;
         end else begin
            rsp_temp_in   = SENT_CRC;
            rsp_status_in = STATUS_CRC;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff   <= req_tdata[7:0];
         s1_family_ff <= req_tdata[15:8];
         s1_absent_ff <= req_tuser;
      end
      rsp_temp_ff   <= rsp_temp_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_temp_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_emit_loads_result: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_emit) |=> rsp_valid_ff)
      else $error("finished frame did not reach the result register");

   a_absent_sentinel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_ABSENT) |-> (rsp_temp_ff == SENT_ABSENT))
      else $error("no-sensor result carries the wrong value");

   a_crc_sentinel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_CRC) |-> (rsp_temp_ff == SENT_CRC))
      else $error("CRC error result carries the wrong value");
`endif

endmodule

`default_nettype wire

// File: rtl/stdec_frame.sv
`default_nettype none

module stdec_frame
   import stdec_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            byte_en,
   input  wire logic [7:0]      data_byte,
   output frame_flags_type      flags,
   output scratch_type          scratch
);

   logic [IDX_W-1:0] index_ff, index_in;
   logic [7:0]       crc_ff, crc_in;
   scratch_type      scratch_ff, scratch_in;

   assign flags.last   = (index_ff >= LAST_POS);
   assign flags.crc_ok = (crc_ff == data_byte);
   assign scratch      = scratch_ff;

   always_comb begin
      index_in   = index_ff;
      crc_in     = crc_ff;
      scratch_in = scratch_ff;
      if (byte_en) begin
         if (flags.last) begin
            index_in = '0;
            crc_in   = '0;
         end else begin
            case (index_ff)
               POS_TEMP_LOW:      scratch_in.temp_low         = data_byte;
               POS_TEMP_HIGH:     scratch_in.temp_high        = data_byte;
               POS_CONFIG:        scratch_in.config_byte      = data_byte;
               POS_COUNT_REMAIN:  scratch_in.count_remain     = data_byte;
               POS_COUNT_PER_DEG: scratch_in.count_per_degree = data_byte;
               default: ;
            endcase
            crc_in   = crc8_update(crc_ff, data_byte);
            index_in = index_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         crc_ff   <= '0;
      end else begin
         index_ff <= index_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      scratch_ff <= scratch_in;
   end

endmodule

`default_nettype wire

// File: rtl/stdec_scale.sv
`default_nettype none

module stdec_scale
   import stdec_pkg::*;
(
   input  wire scratch_type         scratch,
   input  wire logic [7:0]          family_code,
   output logic signed [15:0]       temp_centi
);

   logic [15:0]        raw;
   logic [15:0]        old_raw;
   logic [15:0]        dec_raw;
   logic signed [23:0] prod;
   logic signed [23:0] biased;
   logic signed [23:0] quot;

   assign raw = {scratch.temp_high, scratch.temp_low};

   always_comb begin
      old_raw = {raw[12:0], 3'b000};
      if (scratch.count_per_degree == CPD_FULL) begin
         old_raw = {old_raw[15:4], 4'b0000} + 16'd12 - {8'd0, scratch.count_remain};
      end
      if (family_code == FAMILY_OLD) begin
         dec_raw = old_raw;
      end else begin
         case (scratch.config_byte & RES_BITS)
            RES_9:   dec_raw = raw & 16'hFFF8;
            RES_10:  dec_raw = raw & 16'hFFFC;
            RES_11:  dec_raw = raw & 16'hFFFE;
            default: dec_raw = raw;
         endcase
      end
   end

   // Multiply by 100, then divide by 16 rounding toward zero.
   assign prod       = $signed({{8{dec_raw[15]}}, dec_raw}) * 24'sd100;
   assign biased     = prod + (prod[23] ? 24'sd15 : 24'sd0);
   assign quot       = biased >>> 4;
   assign temp_centi = quot[15:0];

endmodule

`default_nettype wire

// File: bench/tb.sv
`default_nettype none

module tb
   import stdec_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {
      CRC_RAW  = 2'd0,
      CRC_GOOD = 2'd1,
      CRC_BAD  = 2'd2
   } crc_mode_type;

   typedef struct {
      logic [7:0]         data;
      logic [7:0]         family;
      bit                 absent;
      crc_mode_type       crc_mode;
      bit                 typed;
      logic signed [15:0] temp;
      status_type         status;
   } directed_row_type;

   typedef struct packed {
      logic signed [15:0] temp;
      status_type         status;
   } reading_type;

   localparam int DIRECTED_ROWS = 20;
   localparam int HOLD_CYCLES   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   temp_scratchpad_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Shadow of the decoder's frame state.
   logic [IDX_W-1:0] frame_pos = '0;
   logic [7:0]       crc_run   = '0;
   logic [7:0]       sp_lo     = '0;
   logic [7:0]       sp_hi     = '0;
   logic [7:0]       sp_cfg    = '0;
   logic [7:0]       sp_remain = '0;
   logic [7:0]       sp_cpd    = '0;

   reading_type pending_readings[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int pressure_req  = 0;
   int pressure_seen = 0;
   int hold_left     = 0;
   int items_sent    = 0;
   int fail_count    = 0;
   int n_valid       = 0;
   int n_crc_err     = 0;
   int n_absent      = 0;

   directed_row_type directed [DIRECTED_ROWS] = '{
      // Absent sensor straight after reset, all data bits set.
      '{8'hFF, 8'hFF, 1'b1, CRC_RAW, 1'b1, SENT_ABSENT, STATUS_ABSENT},
      // Old family: raw 0x7FFF wraps on the shift, refined with count-remain.
      '{8'hFF, 8'h10, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h7F, 8'h10, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h00, 8'h10, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h00, 8'h10, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'hFF, 8'h10, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'hFF, 8'h10, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'hFF, 8'h10, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h10, 8'h10, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h00, 8'h10, 1'b0, CRC_GOOD, 1'b0, 16'sd0, STATUS_OK},
      // Most negative raw value, an absent item in mid frame, corrupt CRC.
      '{8'h00, 8'h00, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h80, 8'h00, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h00, 8'h00, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h00, 8'h00, 1'b1, CRC_RAW, 1'b1, SENT_ABSENT, STATUS_ABSENT},
      '{8'h00, 8'h00, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h00, 8'h00, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h00, 8'h00, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h00, 8'h00, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h00, 8'h00, 1'b0, CRC_RAW, 1'b0, 16'sd0, STATUS_OK},
      '{8'h00, 8'hFF, 1'b0, CRC_BAD, 1'b1, SENT_CRC, STATUS_CRC}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic logic [7:0] dallas_crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic logic signed [15:0] scale_centi(input logic [7:0] family);
      logic [15:0] raw;
      int          s;
      int          q;
      raw = {sp_hi, sp_lo};
      if (family == FAMILY_OLD) begin
         raw = raw << 3;
         if (sp_cpd == CPD_FULL) begin
            raw = (raw & 16'hFFF0) + 16'd12 - {8'h00, sp_remain};
         end
      end else begin
         case (sp_cfg & RES_BITS)
            RES_9:   raw = raw & 16'hFFF8;
            RES_10:  raw = raw & 16'hFFFC;
            RES_11:  raw = raw & 16'hFFFE;
            default: raw = raw;
         endcase
      end
      s = int'($signed(raw));
      // Integer division truncates toward zero, as the sensor arithmetic does.
      q = (s * 100) / 16;
      return q[15:0];
   endfunction

   function automatic void predict_scratch_byte(input logic [7:0] data, input logic [7:0] family,
                                                input bit absent, output bit produced,
                                                output reading_type rd);
      produced = 1'b0;
      rd       = '{temp: 16'sd0, status: STATUS_OK};
      if (absent) begin
         produced = 1'b1;
         rd       = '{temp: SENT_ABSENT, status: STATUS_ABSENT};
         n_absent++;
      end else if (frame_pos >= LAST_POS) begin
         produced = 1'b1;
         if (crc_run == data) begin
            rd = '{temp: scale_centi(family), status: STATUS_OK};
            n_valid++;
         end else begin
            rd = '{temp: SENT_CRC, status: STATUS_CRC};
            n_crc_err++;
         end
         frame_pos = '0;
         crc_run   = '0;
      end else begin
         case (frame_pos)
            POS_TEMP_LOW:      sp_lo     = data;
            POS_TEMP_HIGH:     sp_hi     = data;
            POS_CONFIG:        sp_cfg    = data;
            POS_COUNT_REMAIN:  sp_remain = data;
            POS_COUNT_PER_DEG: sp_cpd    = data;
            default:           ;
         endcase
         crc_run   = dallas_crc_byte(crc_run, data);
         frame_pos = frame_pos + IDX_W'(1);
      end
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   // Offers one item, waits for it to be taken, then records what it should yield.
   task automatic send_item(input logic [7:0] data, input logic [7:0] family, input bit absent,
                            input bit typed, input logic signed [15:0] temp,
                            input status_type status);
      bit          produced;
      reading_type rd;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {family, data};
      req_tuser  <= absent;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      predict_scratch_byte(data, family, absent, produced, rd);
      if (produced) begin
         if (typed) begin
            rd = '{temp: temp, status: status};
         end
         pending_readings.push_back(rd);
      end
   endtask

   task automatic send_noise_byte(input bit absent);
      send_item(8'($urandom_range(255)), 8'($urandom_range(255)), absent, 1'b0, 16'sd0,
                STATUS_OK);
   endtask

   // A complete scratchpad frame with random content, now and then interrupted by
   // an absent item; the check byte is either the true CRC or a corrupted one.
   task automatic send_frame(input bit good);
      logic [7:0] b;
      logic [7:0] family;
      while (frame_pos != '0) begin
         send_noise_byte(1'b0);
      end
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if ($urandom_range(99) < 4) begin
            send_noise_byte(1'b1);
         end
         b      = 8'($urandom_range(255));
         family = 8'($urandom_range(255));
         if (i == POS_COUNT_PER_DEG && $urandom_range(1)) begin
            b = CPD_FULL;
         end
         if (i == FRAME_BYTES - 1) begin
            b = good ? crc_run : crc_run ^ 8'($urandom_range(1, 255));
            if ($urandom_range(1)) begin
               family = FAMILY_OLD;
            end
         end
         send_item(b, family, 1'b0, 1'b0, 16'sd0, STATUS_OK);
      end
   endtask

   task automatic random_traffic(input int upto);
      int r;
      int k;
      while (items_sent < upto) begin
         r = $urandom_range(99);
         if (r < 80) begin
            send_frame(1'b1);
         end else if (r < 90) begin
            send_frame(1'b0);
         end else begin
            // Broken frame: a few stray bytes; the next frame pads it out.
            k = $urandom_range(1, 8);
            for (int i = 0; i < k; i++) begin
               send_noise_byte($urandom_range(99) < 10);
            end
         end
      end
   endtask

   initial begin
      logic [7:0] b;
      send_idle_pct = 24;
      recv_idle_pct = 69;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         case (directed[i].crc_mode)
            CRC_GOOD: b = crc_run;
            CRC_BAD:  b = crc_run ^ 8'h01;
            default:  b = directed[i].data;
         endcase
         send_item(b, directed[i].family, directed[i].absent, directed[i].typed,
                   directed[i].temp, directed[i].status);
      end

      random_traffic(700);
      send_idle_pct = 69;
      recv_idle_pct = 24;
      random_traffic(1350);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      pressure_req++;
      random_traffic(2000);
      while (frame_pos != '0) begin
         send_noise_byte(1'b0);
      end
      req_tvalid <= 1'b0;

      while (pending_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      $display("Sent %0d scratchpad items: %0d decoded readings, %0d CRC errors, %0d absent.",
               items_sent, n_valid, n_crc_err, n_absent);
      $display("Idling on both sides, a long receiver stall, %0d failures.", fail_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Result side: checks each accepted item and decides the ready for the next cycle.
   initial begin
      reading_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_readings.size() == 0) begin
               note_failure($sformatf("result %0d/%0d with nothing expected",
                                      $signed(rsp_tdata), rsp_tuser));
            end else begin
               want = pending_readings.pop_front();
               if (rsp_tdata !== want.temp) begin
                  note_failure($sformatf("temp_centi expected %0d, got %0d",
                                         want.temp, $signed(rsp_tdata)));
               end
               if (rsp_tuser !== want.status) begin
                  note_failure($sformatf("status expected %0d, got %0d",
                                         want.status, rsp_tuser));
               end
            end
         end
         if (pressure_req != pressure_seen) begin
            pressure_seen = pressure_req;
            hold_left     = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

endmodule

`default_nettype wire
